[hdl/bogm_pkg.sv]
// Shared types and codes for the box occupancy grid marker.
`timescale 1ns / 1ps
package bogm_pkg;

   localparam int FUNC_BITS      = 2;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CELL_SIZE_BITS = 16;
   localparam int EXPANSION_BITS = 16;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_QUERY = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ORIGIN_X  = 3'd0,
      CSR_ORIGIN_Y  = 3'd1,
      CSR_CELL_SIZE = 3'd2,
      CSR_EXPANSION = 3'd3,
      CSR_GRID_COLS = 3'd4,
      CSR_GRID_ROWS = 3'd5
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_CORNER = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   typedef struct packed {
      logic capture;
      logic store;
      logic clear;
      logic set_full;
      logic set_outside;
      logic mul;
      logic corner;
      logic scan_step;
      logic record_hit;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     outside;
      logic     empty;
      logic     hit;
      logic     last;
   } ctrl_sts_type;

endpackage

[hdl/bogm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bogm_ram #(
   parameter int WIDTH     = 96,
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bogm_controller.sv]
// Sequencing state machine for load, query and clear items.
`timescale 1ns / 1ps
module bogm_controller import bogm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            case (sts.func)
               FUNC_LOAD: begin
                  cmd.set_full = sts.full;
                  cmd.store    = !sts.full;
               end
               FUNC_QUERY: begin
                  if (sts.outside) begin
                     cmd.set_outside = 1'b1;
                  end else begin
                     state_in = ST_MUL;
                  end
               end
               FUNC_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CORNER;
         end
         ST_CORNER: begin
            cmd.corner = 1'b1;
            state_in   = sts.empty ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.hit) begin
               cmd.record_hit = 1'b1;
               state_in       = ST_DONE;
            end else if (sts.last) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The scan is only entered with at least one stored box.
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !sts.empty)
      else $error("box scan running over an empty table");

   // An accepted beat always makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not start work");

endmodule

[hdl/bogm_datapath.sv]
// Box table, configuration registers, corner arithmetic and overlap test.
`timescale 1ns / 1ps
module bogm_datapath import bogm_pkg::*; #(
   parameter int MAX_BOXES     = 64,
   parameter int COORD_BITS    = 24,
   parameter int CELL_BITS     = 10,
   parameter int IDX_BITS      = 6,
   parameter int CNT_BITS      = 7,
   parameter int CSR_DATA_BITS = 24,
   parameter int MAX_SIDE_CELLS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_cmd_type                  cmd,
   output ctrl_sts_type                  sts,
   input  logic [FUNC_BITS-1:0]          req_func,
   input  logic signed [COORD_BITS-1:0]  req_box_lo_x,
   input  logic signed [COORD_BITS-1:0]  req_box_lo_y,
   input  logic signed [COORD_BITS-1:0]  req_box_hi_x,
   input  logic signed [COORD_BITS-1:0]  req_box_hi_y,
   input  logic [CELL_BITS-1:0]          req_cell_col,
   input  logic [CELL_BITS-1:0]          req_cell_row,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   output logic                          rsp_strobe,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic                          rsp_occupied,
   output logic [IDX_BITS-1:0]           rsp_hit_box,
   output logic [2*CELL_BITS-1:0]        rsp_cell_address,
   output logic [CNT_BITS-1:0]           rsp_box_total
);

   localparam int GRID_BITS   = CELL_BITS + 1;
   localparam int ADDR_BITS   = 2 * CELL_BITS;
   localparam int MADDR_BITS  = CELL_BITS + GRID_BITS;
   localparam int PROD_BITS   = CELL_BITS + CELL_SIZE_BITS;
   localparam int WIDE_BITS   = (COORD_BITS > PROD_BITS) ? COORD_BITS : PROD_BITS;
   localparam int CORNER_BITS = WIDE_BITS + 2;
   localparam int SUM_BITS    = ((COORD_BITS > EXPANSION_BITS) ? COORD_BITS : EXPANSION_BITS) + 2;
   localparam int ENTRY_BITS  = 4 * COORD_BITS;

   localparam logic signed [SUM_BITS-1:0] SAT_HI =
      {{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SAT_LO =
      {{(SUM_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [SUM_BITS-1:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[COORD_BITS-1:0];
      end else if (v < SAT_LO) begin
         return SAT_LO[COORD_BITS-1:0];
      end
      return v[COORD_BITS-1:0];
   endfunction

   // Configuration registers.
   logic signed [COORD_BITS-1:0]     origin_x_ff, origin_y_ff;
   logic [CELL_SIZE_BITS-1:0]        cell_size_ff;
   logic [EXPANSION_BITS-1:0]        expansion_ff;
   logic [GRID_BITS-1:0]             grid_cols_ff, grid_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         cell_size_ff <= CELL_SIZE_BITS'(256);
         expansion_ff <= '0;
         grid_cols_ff <= GRID_BITS'(MAX_SIDE_CELLS);
         grid_rows_ff <= GRID_BITS'(MAX_SIDE_CELLS);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:  origin_x_ff  <= csr_wdata[COORD_BITS-1:0];
            CSR_ORIGIN_Y:  origin_y_ff  <= csr_wdata[COORD_BITS-1:0];
            CSR_CELL_SIZE: cell_size_ff <= csr_wdata[CELL_SIZE_BITS-1:0];
            CSR_EXPANSION: expansion_ff <= csr_wdata[EXPANSION_BITS-1:0];
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata[GRID_BITS-1:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[GRID_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Captured request beat.
   func_type                     func_ff;
   logic signed [COORD_BITS-1:0] lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic [CELL_BITS-1:0]         col_ff, row_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= func_type'(req_func);
         lo_x_ff <= req_box_lo_x;
         lo_y_ff <= req_box_lo_y;
         hi_x_ff <= req_box_hi_x;
         hi_y_ff <= req_box_hi_y;
         col_ff  <= req_cell_col;
         row_ff  <= req_cell_row;
      end
   end

   // Widened box, saturated to the coordinate range.
   logic signed [SUM_BITS-1:0]   exp_s;
   logic signed [COORD_BITS-1:0] new_lo_x, new_lo_y, new_hi_x, new_hi_y;

   always_comb begin
      exp_s    = signed'({{(SUM_BITS-EXPANSION_BITS){1'b0}}, expansion_ff});
      new_lo_x = sat_coord(SUM_BITS'(lo_x_ff) - exp_s);
      new_lo_y = sat_coord(SUM_BITS'(lo_y_ff) - exp_s);
      new_hi_x = sat_coord(SUM_BITS'(hi_x_ff) + exp_s);
      new_hi_y = sat_coord(SUM_BITS'(hi_y_ff) + exp_s);
   end

   // Box table and fill count.
   logic [CNT_BITS-1:0]   count_ff;
   logic [IDX_BITS-1:0]   chk_ff;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [ENTRY_BITS-1:0] wr_data, rd_data;

   assign wr_data = {new_hi_y, new_hi_x, new_lo_y, new_lo_x};
   assign rd_addr = cmd.corner ? '0 : chk_ff + IDX_BITS'(1);

   bogm_ram #(
      .WIDTH     (ENTRY_BITS),
      .DEPTH     (MAX_BOXES),
      .ADDR_BITS (IDX_BITS)
   ) u_box_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.store) begin
         count_ff <= count_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.corner) begin
         chk_ff <= '0;
      end else if (cmd.scan_step) begin
         chk_ff <= chk_ff + IDX_BITS'(1);
      end
   end

   // Cell corners: products first, then the sums.
   logic [PROD_BITS-1:0]          prod_x_ff, prod_y_ff;
   logic [MADDR_BITS-1:0]         addr_prod, addr_sum;
   logic signed [CORNER_BITS-1:0] min_x, min_y, max_x, max_y, cs_w;
   logic signed [CORNER_BITS-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   always_comb begin
      addr_prod = col_ff * grid_rows_ff;
      addr_sum  = addr_prod + MADDR_BITS'(row_ff);
      cs_w      = signed'(CORNER_BITS'(cell_size_ff));
      min_x     = CORNER_BITS'(origin_x_ff) + signed'(CORNER_BITS'(prod_x_ff));
      min_y     = CORNER_BITS'(origin_y_ff) + signed'(CORNER_BITS'(prod_y_ff));
      max_x     = min_x + cs_w;
      max_y     = min_y + cs_w;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_x_ff <= col_ff * cell_size_ff;
         prod_y_ff <= row_ff * cell_size_ff;
      end
      if (cmd.corner) begin
         min_x_ff <= min_x;
         min_y_ff <= min_y;
         max_x_ff <= max_x;
         max_y_ff <= max_y;
      end
   end

   // Inclusive-edge overlap of the cell with the entry read this cycle.
   logic signed [COORD_BITS-1:0] ent_lo_x, ent_lo_y, ent_hi_x, ent_hi_y;
   logic                         hit_now;

   always_comb begin
      ent_lo_x = signed'(rd_data[COORD_BITS-1:0]);
      ent_lo_y = signed'(rd_data[2*COORD_BITS-1:COORD_BITS]);
      ent_hi_x = signed'(rd_data[3*COORD_BITS-1:2*COORD_BITS]);
      ent_hi_y = signed'(rd_data[4*COORD_BITS-1:3*COORD_BITS]);
      hit_now  = !((min_x_ff > CORNER_BITS'(ent_hi_x)) ||
                   (min_y_ff > CORNER_BITS'(ent_hi_y)) ||
                   (max_x_ff < CORNER_BITS'(ent_lo_x)) ||
                   (max_y_ff < CORNER_BITS'(ent_lo_y)));
   end

   always_comb begin
      sts.func    = func_ff;
      sts.full    = (count_ff == CNT_BITS'(MAX_BOXES));
      sts.outside = (GRID_BITS'(col_ff) >= grid_cols_ff) ||
                    (GRID_BITS'(row_ff) >= grid_rows_ff);
      sts.empty   = (count_ff == '0);
      sts.hit     = hit_now;
      sts.last    = ((CNT_BITS'(chk_ff) + CNT_BITS'(1)) == count_ff);
   end

   // Result registers.
   status_type           res_status_ff;
   logic                 res_occ_ff;
   logic [IDX_BITS-1:0]  res_hit_ff;
   logic [ADDR_BITS-1:0] res_addr_ff;
   logic                 strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_status_ff <= STATUS_OK;
         res_occ_ff    <= 1'b0;
         res_hit_ff    <= '0;
         res_addr_ff   <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish;
         if (cmd.capture) begin
            res_status_ff <= STATUS_OK;
            res_occ_ff    <= 1'b0;
            res_hit_ff    <= '0;
            res_addr_ff   <= '0;
         end
         if (cmd.set_full) begin
            res_status_ff <= STATUS_FULL;
         end
         if (cmd.set_outside) begin
            res_status_ff <= STATUS_OUTSIDE;
         end
         if (cmd.mul) begin
            res_addr_ff <= addr_sum[ADDR_BITS-1:0];
         end
         if (cmd.record_hit) begin
            res_occ_ff <= 1'b1;
            res_hit_ff <= chk_ff;
         end
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = res_status_ff;
   assign rsp_occupied     = res_occ_ff;
   assign rsp_hit_box      = res_hit_ff;
   assign rsp_cell_address = res_addr_ff;
   assign rsp_box_total    = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_BOXES))
      else $error("box count beyond table depth");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |=> !strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_occ_ok: assert property (@(posedge clock) disable iff (reset)
      res_occ_ff |-> (res_status_ff == STATUS_OK))
      else $error("occupied reported with a non-ok status");

endmodule

[hdl/box_occupancy_grid_marker_core.sv]
// Top level of the box occupancy grid marker: controller, datapath and ports.
`timescale 1ns / 1ps
// The block keeps a table of up to MAX_BOXES axis-aligned boxes and answers
// cell queries against it. A beat is taken at a rising edge with start high
// and busy low; exactly one result beat follows, shown on the rsp_ ports for
// one cycle with rsp_strobe high. The receiver cannot hold results off, so it
// must take each result in its strobe cycle. From the accepting edge, a load,
// a clear, an unused code or a query of a cell outside the grid keeps busy
// high through the decode and done states. A query inside the grid keeps busy
// high through decode, multiply, corner, the scan of the boxes tested, up to
// and including the first hit (all stored boxes on a miss, none with an empty
// table), and done. The result strobe is high in the first cycle with busy
// low, and a new beat may be accepted at the edge that ends that cycle, so
// beats sent back to back also wait out each strobe cycle. The query length is
// set by the box table, a RAM with a single registered read port that delivers
// one box per cycle to the overlap test. Coordinates are signed fixed point
// with 8 fraction bits; the user must write configuration through the csr_
// port only while the block is idle, which the block itself does not enforce.
module box_occupancy_grid_marker_core import bogm_pkg::*; #(
   parameter int MAX_BOXES      = 64,
   parameter int COORD_BITS     = 24,
   parameter int MAX_SIDE_CELLS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [FUNC_BITS-1:0]                req_func,
   input  logic signed [COORD_BITS-1:0]        req_box_lo_x,
   input  logic signed [COORD_BITS-1:0]        req_box_lo_y,
   input  logic signed [COORD_BITS-1:0]        req_box_hi_x,
   input  logic signed [COORD_BITS-1:0]        req_box_hi_y,
   input  logic [$clog2(MAX_SIDE_CELLS)-1:0]   req_cell_col,
   input  logic [$clog2(MAX_SIDE_CELLS)-1:0]   req_cell_row,
   input  logic                                csr_we,
   input  logic [CSR_INDEX_BITS-1:0]           csr_index,
   input  logic [((COORD_BITS > CELL_SIZE_BITS) ? COORD_BITS : CELL_SIZE_BITS)-1:0] csr_wdata,
   output logic                                rsp_strobe,
   output logic [STATUS_BITS-1:0]              rsp_status,
   output logic                                rsp_occupied,
   output logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1)-1:0] rsp_hit_box,
   output logic [2*$clog2(MAX_SIDE_CELLS)-1:0] rsp_cell_address,
   output logic [$clog2(MAX_BOXES+1)-1:0]      rsp_box_total
);

   // Cell indices are 10 bits and grid sizes 11 with the default MAX_SIDE_CELLS,
   // so the widest register is either a coordinate or the 16-bit cell size and margin.
   localparam int CELL_BITS     = $clog2(MAX_SIDE_CELLS);
   localparam int IDX_BITS      = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_BITS      = $clog2(MAX_BOXES + 1);
   localparam int CSR_DATA_BITS =
      (COORD_BITS > CELL_SIZE_BITS) ? COORD_BITS : CELL_SIZE_BITS;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   // The controller steps through decode, corner arithmetic and the box scan.
   bogm_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // The datapath holds the box table, the configuration and the results.
   bogm_datapath #(
      .MAX_BOXES      (MAX_BOXES),
      .COORD_BITS     (COORD_BITS),
      .CELL_BITS      (CELL_BITS),
      .IDX_BITS       (IDX_BITS),
      .CNT_BITS       (CNT_BITS),
      .CSR_DATA_BITS  (CSR_DATA_BITS),
      .MAX_SIDE_CELLS (MAX_SIDE_CELLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_func),
      .req_box_lo_x     (req_box_lo_x),
      .req_box_lo_y     (req_box_lo_y),
      .req_box_hi_x     (req_box_hi_x),
      .req_box_hi_y     (req_box_hi_y),
      .req_cell_col     (req_cell_col),
      .req_cell_row     (req_cell_row),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_occupied     (rsp_occupied),
      .rsp_hit_box      (rsp_hit_box),
      .rsp_cell_address (rsp_cell_address),
      .rsp_box_total    (rsp_box_total)
   );

endmodule
